@@ hw/rtl/dlm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlm_pkg
// Types and constants shared by the dense layer multiply-accumulate blocks.
// ----------------------------------------------------------------------------
package dlm_pkg;

    localparam int MAX_INPUTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_INPUTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int MAX_ROWS   = 512;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int ROWCNT_W   = ROW_W + 1;
    localparam int DATA_W     = 16;
    localparam int FRAC_BITS  = 12;
    localparam int ACC_W      = 48;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = ACC_W - FRAC_BITS + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CNT_W;

    localparam logic [CNT_W-1:0]    INPUT_COUNT_RESET = CNT_W'(784);
    localparam logic [ROWCNT_W-1:0] ROW_COUNT_RESET   = ROWCNT_W'(512);

    localparam logic signed [SUM_W-1:0]  SUM_HI  = SUM_W'((2 ** (DATA_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0]  SUM_LO  = -SUM_HI - SUM_W'(1);
    localparam logic signed [DATA_W-1:0] DATA_HI = DATA_W'((2 ** (DATA_W - 1)) - 1);
    localparam logic signed [DATA_W-1:0] DATA_LO = -DATA_HI - DATA_W'(1);

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_WEIGHT = 2'd1,
        FUNC_BIAS   = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_COUNT = 2'd0,
        CFG_ROW_COUNT   = 2'd1,
        CFG_RELU_ENABLE = 2'd2
    } t_cfg_index;

    typedef struct packed {
        t_func                     func;
        logic [ADDR_W-1:0]         index;
        logic signed [DATA_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0]  neuron_value;
        logic [ROW_W-1:0]          row;
        logic                      last;
        logic [ROW_W-1:0]          best_row;
        logic                      saturated;
        logic                      overrun;
    } t_result;

    typedef struct packed {
        logic                      weight;
        logic                      bias;
        logic                      overrun;
        logic signed [DATA_W-1:0]  value;
    } t_mac_ctl;

    typedef struct packed {
        logic                      valid;
        logic                      overrun;
        logic signed [SUM_W-1:0]   sum;
    } t_sum_ctl;

endpackage

@@ hw/rtl/dlm_act_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlm_act_store
// Activation memory with the column counter and overrun tracking.
// ----------------------------------------------------------------------------
module dlm_act_store import dlm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  t_in_item                 i_item,
    input  logic [CNT_W-1:0]         i_input_count,
    output t_mac_ctl                 o_ctl,
    output logic signed [DATA_W-1:0] o_act
);

    logic signed [DATA_W-1:0] r_mem [MAX_INPUTS];
    logic signed [DATA_W-1:0] r_act;
    logic [CNT_W-1:0]         r_col;
    logic [CNT_W-1:0]         n_col;
    logic                     r_overrun;
    logic                     n_overrun;
    t_mac_ctl                 r_ctl;
    t_mac_ctl                 n_ctl;
    logic [CNT_W-1:0]         w_limit;
    logic                     w_take;
    logic                     w_load;

    assign w_limit = (i_input_count > CNT_W'(MAX_INPUTS)) ? CNT_W'(MAX_INPUTS) : i_input_count;
    assign w_load  = i_accept && (i_item.func == FUNC_LOAD);
    assign w_take  = i_accept && (i_item.func == FUNC_WEIGHT) && (r_col < w_limit);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mem[i_item.index] <= i_item.value;
        end
        if (w_take) begin
            r_act <= r_mem[r_col[ADDR_W-1:0]];
        end
    end

    always_comb begin
        n_col         = r_col;
        n_overrun     = r_overrun;
        n_ctl         = '0;
        n_ctl.value   = i_item.value;
        n_ctl.overrun = r_overrun;
        if (i_accept) begin
            unique case (i_item.func)
                FUNC_WEIGHT: begin
                    if (w_take) begin
                        n_col        = r_col + CNT_W'(1);
                        n_ctl.weight = 1'b1;
                    end else begin
                        n_overrun = 1'b1;
                    end
                end
                FUNC_BIAS: begin
                    n_ctl.bias = 1'b1;
                    n_col      = '0;
                    n_overrun  = 1'b0;
                end
                FUNC_LOAD, FUNC_NONE: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_overrun <= 1'b0;
            r_ctl     <= '0;
        end else begin
            r_col     <= n_col;
            r_overrun <= n_overrun;
            r_ctl     <= n_ctl;
        end
    end

    assign o_ctl = r_ctl;
    assign o_act = r_act;

endmodule

@@ hw/rtl/dlm_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlm_mac
// Multiplier stage, 48-bit accumulator and bias addition.
// ----------------------------------------------------------------------------
module dlm_mac import dlm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [DATA_W-1:0] i_act,
    output t_sum_ctl                 o_sum
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    t_mac_ctl                 r_ctl;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    t_sum_ctl                 r_sum;
    t_sum_ctl                 n_sum;

    assign n_prod = $signed(i_act) * $signed(i_ctl.value);

    always_comb begin
        n_acc         = r_acc;
        n_sum         = '0;
        n_sum.overrun = r_ctl.overrun;
        n_sum.sum     = SUM_W'(r_acc >>> FRAC_BITS) + SUM_W'($signed(r_ctl.value));
        if (r_ctl.weight) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
        if (r_ctl.bias) begin
            n_sum.valid = 1'b1;
            n_acc       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
            r_acc <= '0;
            r_sum <= '0;
        end else begin
            r_ctl <= i_ctl;
            r_acc <= n_acc;
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

@@ hw/rtl/dlm_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlm_out
// Saturation, ReLU, row counting and running argmax for each row result.
// ----------------------------------------------------------------------------
module dlm_out import dlm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_sum_ctl            i_sum,
    input  logic [ROWCNT_W-1:0] i_row_count,
    input  logic                i_relu_enable,
    output logic                o_done,
    output t_result             o_result
);

    logic [ROW_W-1:0]          r_row;
    logic [ROW_W-1:0]          n_row;
    logic signed [DATA_W-1:0]  r_best_value;
    logic signed [DATA_W-1:0]  n_best_value;
    logic [ROW_W-1:0]          r_best_index;
    logic [ROW_W-1:0]          n_best_index;
    logic                      r_done;
    t_result                   r_result;
    t_result                   n_result;
    logic signed [DATA_W-1:0]  w_clip;
    logic signed [DATA_W-1:0]  w_value;
    logic                      w_sat;
    logic [ROWCNT_W-1:0]       w_rows;
    logic                      w_last;

    always_comb begin
        w_sat = 1'b1;
        if (i_sum.sum > SUM_HI) begin
            w_clip = DATA_HI;
        end else if (i_sum.sum < SUM_LO) begin
            w_clip = DATA_LO;
        end else begin
            w_clip = DATA_W'(i_sum.sum);
            w_sat  = 1'b0;
        end
        w_value = (i_relu_enable && (w_clip < 0)) ? '0 : w_clip;

        if (i_row_count == '0) begin
            w_rows = ROWCNT_W'(1);
        end else if (i_row_count > ROWCNT_W'(MAX_ROWS)) begin
            w_rows = ROWCNT_W'(MAX_ROWS);
        end else begin
            w_rows = i_row_count;
        end
        w_last = (ROWCNT_W'(r_row) + ROWCNT_W'(1)) >= w_rows;

        n_row        = r_row;
        n_best_value = r_best_value;
        n_best_index = r_best_index;
        if (i_sum.valid) begin
            if ((r_row == '0) || (w_value > r_best_value)) begin
                n_best_value = w_value;
                n_best_index = r_row;
            end
            n_row = w_last ? '0 : r_row + ROW_W'(1);
        end

        n_result.neuron_value = w_value;
        n_result.row          = r_row;
        n_result.last         = w_last;
        n_result.best_row     = n_best_index;
        n_result.saturated    = w_sat;
        n_result.overrun      = i_sum.overrun;
    end

    always_ff @(posedge i_clk) begin
        if (i_sum.valid) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row        <= '0;
            r_best_value <= '0;
            r_best_index <= '0;
            r_done       <= 1'b0;
        end else begin
            r_row        <= n_row;
            r_best_value <= n_best_value;
            r_best_index <= n_best_index;
            r_done       <= i_sum.valid;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ hw/rtl/dense_layer_mac_relu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_layer_mac_relu
// Fully connected layer in Q4.12 with 48-bit accumulation, bias,
// saturation, optional ReLU and running argmax.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle and o_busy stays low. A
// weight item reads the activation memory at the current column, the product
// is registered and then added into the accumulator, so weights stream at one
// per cycle. A bias item yields its result on o_result with o_done high for
// exactly one cycle, after it passes the control, sum and output registers;
// the receiver must capture it then because it cannot stall the block.
module dense_layer_mac_relu import dlm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_in_item              i_item,
    output logic                  o_done,
    output t_result               o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CNT_W-1:0]    r_input_count;
    logic [ROWCNT_W-1:0] r_row_count;
    logic                r_relu_enable;
    logic                w_accept;
    t_mac_ctl            w_mac_ctl;
    logic signed [DATA_W-1:0] w_act;
    t_sum_ctl            w_sum;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_count <= INPUT_COUNT_RESET;
            r_row_count   <= ROW_COUNT_RESET;
            r_relu_enable <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_INPUT_COUNT: r_input_count <= i_cfg_data;
                CFG_ROW_COUNT:   r_row_count   <= i_cfg_data[ROWCNT_W-1:0];
                CFG_RELU_ENABLE: r_relu_enable <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    dlm_act_store u_act_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_item        (i_item),
        .i_input_count (r_input_count),
        .o_ctl         (w_mac_ctl),
        .o_act         (w_act)
    );

    dlm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_act   (w_act),
        .o_sum   (w_sum)
    );

    dlm_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sum         (w_sum),
        .i_row_count   (r_row_count),
        .i_relu_enable (r_relu_enable),
        .o_done        (o_done),
        .o_result      (o_result)
    );

endmodule
